// ----- hw/rtl/resource_graph_deadlock_detector_macros.svh -----
// Assertion macros shared by the checking code of the deadlock detector.
`ifndef RESOURCE_GRAPH_DEADLOCK_DETECTOR_MACROS_SVH
`define RESOURCE_GRAPH_DEADLOCK_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgdd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RGDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgdd assertion failed");

`endif

// ----- hw/rtl/rgdd_pkg.sv -----
`default_nettype none

package rgdd_pkg;

    localparam int NUM_LOCKS_DEF = 16;
    localparam int NUM_PROCS_DEF = 16;
    localparam int ID_W = 4;

    typedef enum logic [1:0] {
        ACT_REQUEST  = 2'd0,
        ACT_ALLOCATE = 2'd1,
        ACT_RELEASE  = 2'd2,
        ACT_DETECT   = 2'd3
    } action_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgdd_edge_mem.sv -----
`default_nettype none

module rgdd_edge_mem
    import rgdd_pkg::*;
#(
    parameter int NODES = NUM_LOCKS_DEF + NUM_PROCS_DEF,
    parameter int NW = $clog2(NODES)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic             wr_en,
    input  wire logic [NW-1:0]    addr,
    input  wire logic [NODES-1:0] wdata,
    output logic      [NODES-1:0] rdata
);

    // A row that was never written since reset reads as all zero.
    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] row_valid_reg;
    logic [NODES-1:0] rd_row_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_valid_reg[addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_row_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/rgdd_stack_mem.sv -----
`default_nettype none

module rgdd_stack_mem
    import rgdd_pkg::*;
#(
    parameter int DEPTH = NUM_LOCKS_DEF + NUM_PROCS_DEF,
    parameter int AW = $clog2(DEPTH),
    parameter int DW = 2 * AW + 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/resource_graph_deadlock_detector.sv -----
// Channel   Ports                                      Handshake
// command   start, action, proc_id, lock_id            taken when start and not busy
// result    strobe, deadlock, is_process, node_id, last  no stall
//
// A request word reads and then writes the process row; an allocate or release word
// does the same for the process row and then for the lock row.
// A detection word runs a depth-first search that tests one edge bit per cycle while
// scanning a row; each reported vertex after the first is read back from the stack.
// busy is high from the accepted word until its update ends or its last result word is registered.
// Reset clears the edge rows through per-row valid bits, so no clearing pass is needed.
// The receiver cannot stall; each result word is shown for exactly one cycle.
`default_nettype none

`include "resource_graph_deadlock_detector_macros.svh"

module resource_graph_deadlock_detector
    import rgdd_pkg::*;
#(
    parameter int NUM_LOCKS = NUM_LOCKS_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      action,
    input  wire logic [ID_W-1:0] proc_id,
    input  wire logic [ID_W-1:0] lock_id,
    output logic                 strobe,
    output logic                 deadlock,
    output logic                 is_process,
    output logic [ID_W-1:0]      node_id,
    output logic                 last
);

    localparam int NODES = NUM_LOCKS + NUM_PROCS;
    localparam int NW = $clog2(NODES);
    localparam int CW = NW + 1;
    localparam int SW = NW + CW;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_UPD_RD_P  = 11'b000_0000_0010,
        ST_UPD_WR_P  = 11'b000_0000_0100,
        ST_UPD_RD_L  = 11'b000_0000_1000,
        ST_UPD_WR_L  = 11'b000_0001_0000,
        ST_ROOT      = 11'b000_0010_0000,
        ST_LOAD      = 11'b000_0100_0000,
        ST_SCAN      = 11'b000_1000_0000,
        ST_POP_WAIT  = 11'b001_0000_0000,
        ST_EMIT_RD   = 11'b010_0000_0000,
        ST_EMIT_OUT  = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    action_t          act_reg, act_next;
    logic [NW-1:0]    pn_reg, pn_next;
    logic [NW-1:0]    ln_reg, ln_next;
    logic [NODES-1:0] visited_reg, visited_next;
    logic [NODES-1:0] on_path_reg, on_path_next;
    logic [CW-1:0]    root_reg, root_next;
    logic [CW-1:0]    depth_reg, depth_next;
    logic [NW-1:0]    cur_v_reg, cur_v_next;
    logic [CW-1:0]    cur_i_reg, cur_i_next;

    logic             strobe_reg, strobe_next;
    logic             deadlock_reg, deadlock_next;
    logic [NW-1:0]    out_node_reg, out_node_next;
    logic             last_reg, last_next;

    logic             edge_rd_en;
    logic             edge_wr_en;
    logic [NW-1:0]    edge_addr;
    logic [NODES-1:0] edge_wdata;
    logic [NODES-1:0] edge_rdata;

    logic             stk_wr_en;
    logic             stk_rd_en;
    logic [NW-1:0]    stk_wr_addr;
    logic [NW-1:0]    stk_rd_addr;
    logic [SW-1:0]    stk_wdata;
    logic [SW-1:0]    stk_rdata;

    logic             ids_ok;
    logic [CW-1:0]    pn_wide;
    logic [NW-1:0]    scan_w;
    logic [CW-1:0]    depth_m1;
    logic [CW-1:0]    depth_m2;
    logic [CW-1:0]    out_ext;
    logic             out_isp;
    logic [CW-1:0]    out_id;

    rgdd_edge_mem #(
        .NODES (NODES),
        .NW    (NW)
    ) u_edge_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (edge_rd_en),
        .wr_en (edge_wr_en),
        .addr  (edge_addr),
        .wdata (edge_wdata),
        .rdata (edge_rdata)
    );

    rgdd_stack_mem #(
        .DEPTH (NODES),
        .AW    (NW),
        .DW    (SW)
    ) u_stack_mem (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wdata   (stk_wdata),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rdata   (stk_rdata)
    );

    assign ids_ok   = ({2'b00, proc_id} < 6'(NUM_PROCS)) && ({2'b00, lock_id} < 6'(NUM_LOCKS));
    assign pn_wide  = CW'(NUM_LOCKS) + CW'(proc_id);
    assign scan_w   = cur_i_reg[NW-1:0];
    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);

    assign stk_wr_addr = depth_m1[NW-1:0];
    assign stk_wdata   = {cur_v_reg, cur_i_reg + CW'(1)};
    assign stk_rd_addr = (state_reg == ST_EMIT_RD) ? depth_m1[NW-1:0] : depth_m2[NW-1:0];

    always_comb
    begin
        unique case (state_reg)
            ST_UPD_RD_P, ST_UPD_WR_P: edge_addr = pn_reg;
            ST_UPD_RD_L, ST_UPD_WR_L: edge_addr = ln_reg;
            default:                  edge_addr = cur_v_reg;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        pn_next       = pn_reg;
        ln_next       = ln_reg;
        visited_next  = visited_reg;
        on_path_next  = on_path_reg;
        root_next     = root_reg;
        depth_next    = depth_reg;
        cur_v_next    = cur_v_reg;
        cur_i_next    = cur_i_reg;
        strobe_next   = 1'b0;
        deadlock_next = deadlock_reg;
        out_node_next = out_node_reg;
        last_next     = last_reg;
        edge_rd_en    = 1'b0;
        edge_wr_en    = 1'b0;
        edge_wdata    = edge_rdata;
        stk_wr_en     = 1'b0;
        stk_rd_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next = action_t'(action);
                    pn_next  = pn_wide[NW-1:0];
                    ln_next  = NW'(lock_id);
                    if (action_t'(action) == ACT_DETECT)
                    begin
                        visited_next = '0;
                        on_path_next = '0;
                        root_next    = '0;
                        state_next   = ST_ROOT;
                    end
                    else if (ids_ok)
                    begin
                        state_next = ST_UPD_RD_P;
                    end
                end
            end
            ST_UPD_RD_P:
            begin
                edge_rd_en = 1'b1;
                state_next = ST_UPD_WR_P;
            end
            ST_UPD_WR_P:
            begin
                edge_wr_en = 1'b1;
                if (act_reg == ACT_REQUEST)
                begin
                    edge_wdata = edge_rdata | (NODES'(1) << ln_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    edge_wdata = edge_rdata & ~(NODES'(1) << ln_reg);
                    state_next = ST_UPD_RD_L;
                end
            end
            ST_UPD_RD_L:
            begin
                edge_rd_en = 1'b1;
                state_next = ST_UPD_WR_L;
            end
            ST_UPD_WR_L:
            begin
                edge_wr_en = 1'b1;
                if (act_reg == ACT_ALLOCATE)
                begin
                    edge_wdata = edge_rdata | (NODES'(1) << pn_reg);
                end
                else
                begin
                    edge_wdata = edge_rdata & ~(NODES'(1) << pn_reg);
                end
                state_next = ST_IDLE;
            end
            ST_ROOT:
            begin
                if (root_reg == CW'(NODES))
                begin
                    strobe_next   = 1'b1;
                    deadlock_next = 1'b0;
                    out_node_next = '0;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (visited_reg[root_reg[NW-1:0]])
                begin
                    root_next = root_reg + CW'(1);
                end
                else
                begin
                    visited_next[root_reg[NW-1:0]] = 1'b1;
                    on_path_next[root_reg[NW-1:0]] = 1'b1;
                    depth_next = CW'(1);
                    cur_v_next = root_reg[NW-1:0];
                    cur_i_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                edge_rd_en = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cur_i_reg == CW'(NODES))
                begin
                    on_path_next[cur_v_reg] = 1'b0;
                    depth_next = depth_m1;
                    if (depth_reg == CW'(1))
                    begin
                        root_next  = root_reg + CW'(1);
                        state_next = ST_ROOT;
                    end
                    else
                    begin
                        stk_rd_en  = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end
                else if (edge_rdata[scan_w] && !visited_reg[scan_w])
                begin
                    stk_wr_en = 1'b1;
                    visited_next[scan_w] = 1'b1;
                    on_path_next[scan_w] = 1'b1;
                    depth_next = depth_reg + CW'(1);
                    cur_v_next = scan_w;
                    cur_i_next = '0;
                    state_next = ST_LOAD;
                end
                else if (edge_rdata[scan_w] && on_path_reg[scan_w])
                begin
                    strobe_next   = 1'b1;
                    deadlock_next = 1'b1;
                    out_node_next = cur_v_reg;
                    last_next     = (depth_reg == CW'(1));
                    depth_next    = depth_m1;
                    state_next    = (depth_reg == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
                else
                begin
                    cur_i_next = cur_i_reg + CW'(1);
                end
            end
            ST_POP_WAIT:
            begin
                cur_v_next = stk_rdata[SW-1:CW];
                cur_i_next = stk_rdata[CW-1:0];
                state_next = ST_LOAD;
            end
            ST_EMIT_RD:
            begin
                stk_rd_en  = 1'b1;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                strobe_next   = 1'b1;
                deadlock_next = 1'b1;
                out_node_next = stk_rdata[SW-1:CW];
                last_next     = (depth_reg == CW'(1));
                depth_next    = depth_m1;
                state_next    = (depth_reg == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            visited_reg <= '0;
            on_path_reg <= '0;
            root_reg    <= '0;
            depth_reg   <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            on_path_reg <= on_path_next;
            root_reg    <= root_next;
            depth_reg   <= depth_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pn_reg       <= pn_next;
        ln_reg       <= ln_next;
        cur_v_reg    <= cur_v_next;
        cur_i_reg    <= cur_i_next;
        deadlock_reg <= deadlock_next;
        out_node_reg <= out_node_next;
        last_reg     <= last_next;
    end

    // Node numbers below the lock count are locks; the rest are processes.
    assign out_ext = CW'(out_node_reg);
    assign out_isp = (out_ext >= CW'(NUM_LOCKS));
    assign out_id  = out_isp ? (out_ext - CW'(NUM_LOCKS)) : out_ext;

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign deadlock   = deadlock_reg;
    assign is_process = deadlock_reg & out_isp;
    assign node_id    = deadlock_reg ? ID_W'(out_id) : '0;
    assign last       = last_reg;

    `RGDD_ASSERT_NEXT(a_detect_goes_busy, clk, rst_n,
        start && !busy && (action == ACT_DETECT), busy)
    `RGDD_ASSERT_NOW(a_path_marks_visited, clk, rst_n,
        1'b1, (on_path_reg & ~visited_reg) == '0)
    `RGDD_ASSERT_NOW(a_scan_depth_bounded, clk, rst_n,
        state_reg == ST_SCAN, (depth_reg != '0) && (depth_reg <= CW'(NODES)))
    `RGDD_ASSERT_NEXT(a_last_ends_run, clk, rst_n,
        strobe_reg && last_reg, !strobe_reg)

endmodule

`default_nettype wire

// ----- sim/deadlock_path_checker.sv -----
module deadlock_path_checker
    import rgdd_pkg::*;
#(
    parameter int NUM_LOCKS = NUM_LOCKS_DEF,
    parameter int NUM_PROCS = NUM_PROCS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [1:0]      action,
    input  logic [ID_W-1:0] proc_id,
    input  logic [ID_W-1:0] lock_id,
    input  logic            strobe,
    input  logic            deadlock,
    input  logic            is_process,
    input  logic [ID_W-1:0] node_id,
    input  logic            last,
    output int              errors,
    output int              pending
);

    localparam int NODE_COUNT = NUM_LOCKS + NUM_PROCS;

    typedef struct packed {
        logic            deadlock;
        logic            is_process;
        logic [ID_W-1:0] node_id;
        logic            last;
    } path_word_t;

    logic [NODE_COUNT-1:0] wait_for [NODE_COUNT];
    path_word_t            expected_words [$];
    int                    fail_count;

    initial
    begin
        errors = 0;
        pending = 0;
        fail_count = 0;
    end

    task automatic apply_command(action_t act, int p, int l);
        int pn;
        if (p >= NUM_PROCS || l >= NUM_LOCKS)
            return;
        pn = NUM_LOCKS + p;
        case (act)
            ACT_REQUEST:
            begin
                wait_for[pn][l] = 1'b1;
            end
            ACT_ALLOCATE:
            begin
                wait_for[l][pn] = 1'b1;
                wait_for[pn][l] = 1'b0;
            end
            ACT_RELEASE:
            begin
                wait_for[pn][l] = 1'b0;
                wait_for[l][pn] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // Depth-first search from every unvisited node in index order; the first edge
    // back onto the current path ends the run, and the path is reported deepest first.
    task automatic predict_detection();
        logic [NODE_COUNT-1:0] seen;
        logic [NODE_COUNT-1:0] on_path;
        int                    stack_node [NODE_COUNT];
        int                    stack_next [NODE_COUNT];
        int                    depth;
        int                    v;
        int                    i;
        int                    w;
        int                    n;
        int                    root;
        bit                    pushed;
        bit                    found;
        path_word_t            word;
        seen = '0;
        on_path = '0;
        found = 1'b0;
        for (root = 0; root < NODE_COUNT && !found; root++)
        begin
            if (!seen[root])
            begin
                depth = 1;
                stack_node[0] = root;
                stack_next[0] = 0;
                seen[root] = 1'b1;
                on_path[root] = 1'b1;
                while (depth > 0 && !found)
                begin
                    v = stack_node[depth-1];
                    i = stack_next[depth-1];
                    pushed = 1'b0;
                    while (i < NODE_COUNT && !pushed && !found)
                    begin
                        w = i;
                        i++;
                        if (wait_for[v][w])
                        begin
                            stack_next[depth-1] = i;
                            if (!seen[w])
                            begin
                                if (depth < NODE_COUNT)
                                begin
                                    stack_node[depth] = w;
                                    stack_next[depth] = 0;
                                    depth++;
                                    seen[w] = 1'b1;
                                    on_path[w] = 1'b1;
                                    pushed = 1'b1;
                                end
                            end
                            else if (on_path[w])
                            begin
                                found = 1'b1;
                                for (int k = 0; k < depth; k++)
                                begin
                                    n = stack_node[depth-1-k];
                                    word.deadlock = 1'b1;
                                    word.is_process = (n >= NUM_LOCKS);
                                    word.node_id = ID_W'((n >= NUM_LOCKS) ? n - NUM_LOCKS : n);
                                    word.last = (k == depth - 1);
                                    expected_words.push_back(word);
                                end
                            end
                        end
                    end
                    if (!pushed && !found)
                    begin
                        on_path[v] = 1'b0;
                        depth--;
                    end
                end
            end
        end
        if (!found)
        begin
            word = '{deadlock: 1'b0, is_process: 1'b0, node_id: '0, last: 1'b1};
            expected_words.push_back(word);
        end
    endtask

    function automatic int field_differs(string label, logic [ID_W-1:0] want,
                                         logic [ID_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        path_word_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < NODE_COUNT; r++)
                wait_for[r] = '0;
            expected_words.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: result word expected none, got deadlock %0d is_process %0d node_id %0d last %0d",
                             $time, deadlock, is_process, node_id, last);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    fail_count += field_differs("deadlock", want.deadlock, deadlock);
                    fail_count += field_differs("is_process", want.is_process, is_process);
                    fail_count += field_differs("node_id", want.node_id, node_id);
                    fail_count += field_differs("last", want.last, last);
                end
            end
            if (start && !busy)
            begin
                if (action_t'(action) == ACT_DETECT)
                    predict_detection();
                else
                    apply_command(action_t'(action), proc_id, lock_id);
            end
        end
        errors <= fail_count;
        pending <= expected_words.size();
    end

endmodule

// ----- sim/resource_graph_deadlock_detector_tb.sv -----
module resource_graph_deadlock_detector_tb;

    import rgdd_pkg::*;

    localparam int WORD_TARGET = 240;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 1200;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic [1:0]      action;
    logic [ID_W-1:0] proc_id;
    logic [ID_W-1:0] lock_id;
    logic            busy;
    logic            strobe;
    logic            deadlock;
    logic            is_process;
    logic [ID_W-1:0] node_id;
    logic            last;
    int              errors;
    int              pending;
    int              cycle_count;
    int              words_sent;

    resource_graph_deadlock_detector u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .proc_id    (proc_id),
        .lock_id    (lock_id),
        .strobe     (strobe),
        .deadlock   (deadlock),
        .is_process (is_process),
        .node_id    (node_id),
        .last       (last)
    );

    deadlock_path_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .proc_id    (proc_id),
        .lock_id    (lock_id),
        .strobe     (strobe),
        .deadlock   (deadlock),
        .is_process (is_process),
        .node_id    (node_id),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic scramble_fields();
        action <= 2'($urandom_range(3));
        proc_id <= ID_W'($urandom);
        lock_id <= ID_W'($urandom);
    endtask

    task automatic send_word(action_t act, logic [ID_W-1:0] p, logic [ID_W-1:0] l);
        int gap;
        start <= 1'b1;
        action <= act;
        proc_id <= p;
        lock_id <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (!(words_sent >= 120 && words_sent < 180) && $urandom_range(99) < 36)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            start <= 1'b0;
            scramble_fields();
            repeat (gap - 1)
            begin
                @(posedge clk);
                scramble_fields();
            end
            @(posedge clk);
        end
    endtask

    task automatic build_ring(int k);
        logic [ID_W-1:0] lock_pick [16];
        logic [ID_W-1:0] proc_pick [16];
        logic [ID_W-1:0] swap;
        int              j;
        for (int i = 0; i < 16; i++)
        begin
            lock_pick[i] = ID_W'(i);
            proc_pick[i] = ID_W'(i);
        end
        for (int i = 15; i > 0; i--)
        begin
            j = $urandom_range(i);
            swap = lock_pick[i];
            lock_pick[i] = lock_pick[j];
            lock_pick[j] = swap;
            j = $urandom_range(i);
            swap = proc_pick[i];
            proc_pick[i] = proc_pick[j];
            proc_pick[j] = swap;
        end
        for (int i = 0; i < k; i++)
            send_word(ACT_ALLOCATE, proc_pick[i], lock_pick[i]);
        for (int i = 0; i < k; i++)
            send_word(ACT_REQUEST, proc_pick[i], lock_pick[(i + 1) % k]);
        if ($urandom_range(99) < 25)
        begin
            j = $urandom_range(k - 1);
            send_word(ACT_RELEASE, proc_pick[j], lock_pick[(j + 1) % k]);
        end
        send_word(ACT_DETECT, ID_W'($urandom), ID_W'($urandom));
        if ($urandom_range(99) < 70)
        begin
            for (int i = 0; i < k; i++)
            begin
                send_word(ACT_RELEASE, proc_pick[i], lock_pick[i]);
                if (k > 1)
                    send_word(ACT_RELEASE, proc_pick[i], lock_pick[(i + 1) % k]);
            end
        end
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_REQUEST;
        proc_id = '0;
        lock_id = '0;
        cycle_count = 0;
        words_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(ACT_DETECT, 4'd0, 4'd0);
        send_word(ACT_REQUEST, 4'd15, 4'd15);
        send_word(ACT_ALLOCATE, 4'd15, 4'd15);
        send_word(ACT_DETECT, 4'd15, 4'd15);
        send_word(ACT_REQUEST, 4'd15, 4'd15);
        send_word(ACT_DETECT, 4'd0, 4'd15);
        send_word(ACT_RELEASE, 4'd15, 4'd15);
        send_word(ACT_DETECT, 4'd15, 4'd0);
        send_word(ACT_ALLOCATE, 4'd0, 4'd0);
        send_word(ACT_ALLOCATE, 4'd15, 4'd15);
        send_word(ACT_REQUEST, 4'd0, 4'd15);
        send_word(ACT_REQUEST, 4'd15, 4'd0);
        send_word(ACT_DETECT, 4'd0, 4'd0);
        send_word(ACT_REQUEST, 4'd0, 4'd0);
        send_word(ACT_DETECT, 4'd0, 4'd0);
        send_word(ACT_RELEASE, 4'd0, 4'd0);
        send_word(ACT_DETECT, 4'd0, 4'd0);
        send_word(ACT_RELEASE, 4'd7, 4'd9);
        send_word(ACT_ALLOCATE, 4'd3, 4'd0);
        send_word(ACT_REQUEST, 4'd3, 4'd5);
        send_word(ACT_ALLOCATE, 4'd8, 4'd5);
        send_word(ACT_REQUEST, 4'd8, 4'd5);
        send_word(ACT_DETECT, 4'd0, 4'd0);

        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(99) < 60)
            begin
                build_ring($urandom_range(1, 8));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(99);
                    if (pick < 30)
                        send_word(ACT_REQUEST, ID_W'($urandom), ID_W'($urandom));
                    else if (pick < 55)
                        send_word(ACT_ALLOCATE, ID_W'($urandom), ID_W'($urandom));
                    else if (pick < 85)
                        send_word(ACT_RELEASE, ID_W'($urandom), ID_W'($urandom));
                    else
                        send_word(ACT_DETECT, ID_W'($urandom), ID_W'($urandom));
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
